// ----- rtl/ffra_pkg.sv -----
// Shared types, codes and constants of the frame-fenced ring allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

  // Default parameter values
  localparam int unsigned FrameQueueDepthDef = 4;
  localparam int unsigned AddrBitsDef        = 24;

  // Fixed field widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned ReqW    = 25;
  localparam int unsigned FidW    = 64;
  localparam int unsigned OffsetW = 24;
  localparam int unsigned StatusW = 3;
  localparam int unsigned UsedW   = 25;
  localparam int unsigned BlocksW = 17;

  // One block is 256 bytes
  localparam int unsigned BlockShift = 8;
  localparam logic [BlocksW-1:0] BlocksReset = BlocksW'(4096);

  // Function codes
  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC    = 2'd0,
    FUNC_FINISH   = 2'd1,
    FUNC_COMPLETE = 2'd2
  } func_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK          = 3'd0,
    STATUS_NO_SPACE    = 3'd1,
    STATUS_QUEUE_FULL  = 3'd2,
    STATUS_QUEUE_EMPTY = 3'd3,
    STATUS_MISMATCH    = 3'd4
  } status_e;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // capture input word and read the oldest mark
    logic exec;    // apply the operation and load the result register
    logic clear;   // load buffer size and clear pointers and queue
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ffra_ctrl.sv -----
// Controller: handshakes and sequencing of one operation at a time.
`timescale 1ns / 1ps
`default_nettype none

module ffra_ctrl
  import ffra_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Hold state and result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cfg_ready_o = 1'b1;
    cmd_o.clear = cfg_valid_i;

    // drop the result word once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        // take a word only when the result register is free by the next cycle
        in_ready_o = !out_valid_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/ffra_dp.sv -----
// Datapath: ring pointers, frame mark queue and result register.
`timescale 1ns / 1ps
`default_nettype none

module ffra_dp
  import ffra_pkg::*;
#(
  parameter int unsigned FRAME_QUEUE_DEPTH = FrameQueueDepthDef,
  parameter int unsigned ADDR_BITS         = AddrBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  input  wire logic [BlocksW-1:0] cfg_buffer_blocks_i,
  input  wire logic [FuncW-1:0]   func_i,
  input  wire logic [ReqW-1:0]    alloc_bytes_i,
  input  wire logic [FidW-1:0]    frame_id_i,
  output logic [OffsetW-1:0]      offset_o,
  output logic [StatusW-1:0]      status_o,
  output logic [UsedW-1:0]        used_bytes_o
);

  // Pointer width holds the buffer size itself
  localparam int unsigned PtrW  = ADDR_BITS + 1;
  localparam int unsigned CalcW = ((PtrW > ReqW) ? PtrW : ReqW) + 2;
  localparam int unsigned SatW  = (BlocksW > ADDR_BITS - 7) ? BlocksW : ADDR_BITS - 7;
  localparam int unsigned QPtrW = (FRAME_QUEUE_DEPTH > 1) ? $clog2(FRAME_QUEUE_DEPTH) : 1;
  localparam int unsigned QCntW = $clog2(FRAME_QUEUE_DEPTH + 1);
  localparam logic [QPtrW-1:0] QLast  = QPtrW'(FRAME_QUEUE_DEPTH - 1);
  localparam logic [QCntW-1:0] QDepth = QCntW'(FRAME_QUEUE_DEPTH);
  localparam logic [SatW-1:0]  MaxBlocks = SatW'(1) << (ADDR_BITS - BlockShift);

  // Control state
  logic [BlocksW-1:0] blocks_q;
  logic [PtrW-1:0]    head_q, head_d;
  logic [PtrW-1:0]    tail_q, tail_d;
  logic [PtrW-1:0]    used_q, used_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;

  // Captured input word and mark read data
  logic [FuncW-1:0]   func_q;
  logic [ReqW-1:0]    req_q;
  logic [FidW-1:0]    fid_q;
  logic [FidW-1:0]    mark_fid_q;
  logic [PtrW-1:0]    mark_tail_q;

  // Mark queue storage
  logic [FidW-1:0]    mark_fid_mem [FRAME_QUEUE_DEPTH];
  logic [PtrW-1:0]    mark_tail_mem [FRAME_QUEUE_DEPTH];
  logic               push;

  // Result register
  logic [OffsetW-1:0] offset_q;
  logic [StatusW-1:0] status_q;
  logic [UsedW-1:0]   used_out_q;

  // Operation results
  logic [CalcW-1:0]   offset_d;
  status_e            status_d;

  // Wide working copies
  logic [SatW-1:0]    blocks_ext;
  logic [SatW-1:0]    blocks_sat;
  logic [CalcW-1:0]   size;
  logic [CalcW-1:0]   head_w, tail_w, used_w, req_w, mt_w;
  logic [CalcW-1:0]   tail_plus;
  logic [CalcW-1:0]   skip;
  logic [CalcW-1:0]   grow_fit, grow_wrap;
  logic [CalcW-1:0]   free_base, free_sub, free_val;

  // Buffer size in bytes, saturated to the address range
  assign blocks_ext = SatW'(blocks_q);
  assign blocks_sat = (blocks_ext > MaxBlocks) ? MaxBlocks : blocks_ext;
  assign size       = CalcW'(blocks_sat) << BlockShift;

  assign head_w    = CalcW'(head_q);
  assign tail_w    = CalcW'(tail_q);
  assign used_w    = CalcW'(used_q);
  assign req_w     = CalcW'(req_q);
  assign mt_w      = CalcW'(mark_tail_q);
  assign tail_plus = tail_w + req_w;
  assign skip      = (size > tail_w) ? size - tail_w : '0;
  assign grow_fit  = used_w + req_w;
  assign grow_wrap = used_w + skip + req_w;

  // Used count left after freeing up to the oldest mark
  assign free_base = used_w + head_w;
  assign free_sub  = (mark_tail_q >= head_q) ? mt_w : mt_w + size;
  assign free_val  = (used_q == '0 || free_base < free_sub) ? '0 : free_base - free_sub;

  // Next state of the allocator for the captured operation
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    used_d   = used_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    push     = 1'b0;
    offset_d = '0;
    status_d = STATUS_OK;

    case (func_q)
      FUNC_ALLOC: begin
        status_d = STATUS_NO_SPACE;
        if (used_w != size) begin
          if (tail_q >= head_q) begin
            if (tail_plus <= size) begin
              offset_d = tail_w;
              tail_d   = PtrW'(tail_plus);
              used_d   = PtrW'((grow_fit > size) ? size : grow_fit);
              status_d = STATUS_OK;
            end else if (req_w <= head_w) begin
              // wrap to the start, the skipped end counts as used
              tail_d   = PtrW'(req_w);
              used_d   = PtrW'((grow_wrap > size) ? size : grow_wrap);
              status_d = STATUS_OK;
            end
          end else if (tail_plus <= head_w) begin
            offset_d = tail_w;
            tail_d   = PtrW'(tail_plus);
            used_d   = PtrW'((grow_fit > size) ? size : grow_fit);
            status_d = STATUS_OK;
          end
        end
      end
      FUNC_FINISH: begin
        if (cnt_q >= QDepth) begin
          status_d = STATUS_QUEUE_FULL;
        end else begin
          push     = 1'b1;
          wr_ptr_d = (wr_ptr_q == QLast) ? '0 : wr_ptr_q + 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      FUNC_COMPLETE: begin
        if (cnt_q == '0) begin
          status_d = STATUS_QUEUE_EMPTY;
        end else if (mark_fid_q != fid_q) begin
          status_d = STATUS_MISMATCH;
        end else begin
          used_d   = PtrW'((free_val > size) ? size : free_val);
          head_d   = mark_tail_q;
          rd_ptr_d = (rd_ptr_q == QLast) ? '0 : rd_ptr_q + 1'b1;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      default: begin
        status_d = STATUS_OK;
      end
    endcase
  end

  // Hold pointers and size; clear on a size write, advance on execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q <= BlocksReset;
      head_q   <= '0;
      tail_q   <= '0;
      used_q   <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.clear) begin
      blocks_q <= cfg_buffer_blocks_i;
      head_q   <= '0;
      tail_q   <= '0;
      used_q   <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.exec) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      used_q   <= used_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Capture the input word and read the oldest mark
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q      <= func_i;
      req_q       <= alloc_bytes_i;
      fid_q       <= frame_id_i;
      mark_fid_q  <= mark_fid_mem[rd_ptr_q];
      mark_tail_q <= mark_tail_mem[rd_ptr_q];
    end
  end

  // Push a mark at the write pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push) begin
      mark_fid_mem[wr_ptr_q]  <= fid_q;
      mark_tail_mem[wr_ptr_q] <= tail_q;
    end
  end

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      offset_q   <= offset_d[OffsetW-1:0];
      status_q   <= status_d;
      used_out_q <= UsedW'(CalcW'(used_d));
    end
  end

  assign offset_o     = offset_q;
  assign status_o     = status_q;
  assign used_bytes_o = used_out_q;

endmodule

`default_nettype wire

// ----- rtl/frame_fenced_ring_allocator.sv -----
// Top level of the frame-fenced ring allocator.
//
// Ring allocator over buffer_blocks * 256 bytes with a queue of frame marks.
// Each request word is captured and the oldest frame mark read from the
// mark queue memory, then the operation is applied and the result register
// loaded; no new word is taken while an operation is being applied. A new
// word is accepted while the previous result is being taken. Writing the
// size register clears the pointers, the used count and the mark queue in
// the same cycle; the configuration port is always ready, and the user must
// write it only while idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module frame_fenced_ring_allocator
  import ffra_pkg::*;
#(
  parameter int unsigned FRAME_QUEUE_DEPTH = FrameQueueDepthDef,
  parameter int unsigned ADDR_BITS         = AddrBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [BlocksW-1:0] cfg_buffer_blocks_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FuncW-1:0]   func_i,
  input  wire logic [ReqW-1:0]    alloc_bytes_i,
  input  wire logic [FidW-1:0]    frame_id_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [OffsetW-1:0]      offset_o,
  output logic [StatusW-1:0]      status_o,
  output logic [UsedW-1:0]        used_bytes_o
);

  cmd_t cmd;

  // Sequence handshakes
  ffra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  // Hold allocator state and compute results
  ffra_dp #(
    .FRAME_QUEUE_DEPTH (FRAME_QUEUE_DEPTH),
    .ADDR_BITS         (ADDR_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_buffer_blocks_i (cfg_buffer_blocks_i),
    .func_i              (func_i),
    .alloc_bytes_i       (alloc_bytes_i),
    .frame_id_i          (frame_id_i),
    .offset_o            (offset_o),
    .status_o            (status_o),
    .used_bytes_o        (used_bytes_o)
  );

endmodule

`default_nettype wire
